// File: hw/rtl/block_cipher_key_expansion_core_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef BLOCK_CIPHER_KEY_EXPANSION_CORE_MACROS_SVH
`define BLOCK_CIPHER_KEY_EXPANSION_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCKE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCKE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bcke_pkg.sv
`default_nettype none
package bcke_pkg;

  localparam logic [6:0] LFSR_SEED   = 7'h5A;
  localparam int         GROUP_COUNT = 16;
  localparam int         GRP_W       = 4;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
  } in_t;

  typedef struct packed {
    logic        word_kind;
    logic [3:0]  group_index;
    logic [63:0] key_bytes;
    logic        last_result;
  } out_t;

  localparam logic WORD_WHITEN = 1'b0;
  localparam logic WORD_GROUP  = 1'b1;

  typedef struct packed {
    logic load;
    logic emit_whiten;
    logic emit_group;
  } cmd_t;

  typedef struct packed {
    logic group_last;
  } status_t;

  // One step of the round-constant LFSR: shift right, new top bit is bit 3 xor bit 0.
  function automatic logic [6:0] lfsr_step(input logic [6:0] v);
    lfsr_step = {v[3] ^ v[0], v[6:1]};
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bcke_ctrl.sv
`default_nettype none
module bcke_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output bcke_pkg::cmd_t         cmd,
  input  wire bcke_pkg::status_t status
);
  import bcke_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WHITEN = 3'b010,
    S_GROUP  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_WHITEN;
      end
      S_WHITEN: begin
        state_nxt = S_GROUP;
      end
      S_GROUP: begin
        if (status.group_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign cmd.load         = (state_r == S_IDLE) && start;
  assign cmd.emit_whiten  = (state_r == S_WHITEN);
  assign cmd.emit_group   = (state_r == S_GROUP);

endmodule
`default_nettype wire

// File: hw/rtl/bcke_datapath.sv
`default_nettype none
module bcke_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bcke_pkg::in_t   in_data,
  input  wire bcke_pkg::cmd_t  cmd,
  output bcke_pkg::status_t    status,
  output logic                 out_valid,
  output bcke_pkg::out_t       out_data
);
  import bcke_pkg::*;

  logic [63:0]      key_lo_r, key_hi_r;
  logic [6:0]       lfsr_r, lfsr_nxt;
  logic [GRP_W-1:0] grp_r, grp_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;
  logic [63:0]      whiten_word;
  logic [63:0]      group_word;

  assign whiten_word = {key_lo_r[31:0], key_hi_r[63:32]};

  // Eight subkeys per cycle: the LFSR chain runs eight steps, and each subkey takes
  // its byte from one key half at an offset rotated by the pair of groups.
  always_comb begin
    logic [6:0]  c;
    logic [63:0] half;
    logic [2:0]  rot;
    logic [2:0]  idx;
    c    = lfsr_r;
    half = grp_r[0] ? key_hi_r : key_lo_r;
    rot  = grp_r[3:1];
    group_word = '0;
    for (int k = 0; k < 8; k++) begin
      idx = 3'(k) - rot;
      group_word[8*k +: 8] = half[8*idx +: 8] + {1'b0, c};
      c = lfsr_step(c);
    end
    lfsr_nxt = c;
  end

  assign status.group_last = (grp_r == GRP_W'(GROUP_COUNT - 1));

  always_comb begin
    grp_nxt       = grp_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    if (cmd.emit_whiten) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.word_kind   = WORD_WHITEN;
      out_data_nxt.group_index = '0;
      out_data_nxt.key_bytes   = whiten_word;
      out_data_nxt.last_result = 1'b0;
    end else if (cmd.emit_group) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.word_kind   = WORD_GROUP;
      out_data_nxt.group_index = grp_r;
      out_data_nxt.key_bytes   = group_word;
      out_data_nxt.last_result = status.group_last;
      grp_nxt                  = grp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r      <= LFSR_SEED;
      grp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.load) begin
        lfsr_r <= LFSR_SEED;
        grp_r  <= '0;
      end else if (cmd.emit_group) begin
        lfsr_r <= lfsr_nxt;
        grp_r  <= grp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_lo_r <= in_data.key_low;
      key_hi_r <= in_data.key_high;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: hw/rtl/block_cipher_key_expansion_core.sv
`default_nettype none
// Key schedule for a 64-bit lightweight block cipher with a 128-bit master key.
// A request is taken at a rising edge where start is high and busy is low; in_data
// carries the key as two 64-bit halves.
// Each key yields a burst of 17 results on out_data, one per cycle, each marked by
// out_valid for exactly one cycle: first the whitening key word, then 16 subkey
// group words of eight subkeys, the last one flagged by last_result.
// The whitening word is registered out of the S_WHITEN state that the request
// edge enters, and the burst then runs without gaps. Eight subkeys are formed per
// cycle by an eight-step chain of the round-constant LFSR and eight byte adders.
// busy is high from S_WHITEN through the last S_GROUP state, and the next request
// is taken only once it has fallen, so no new key is taken while a burst runs; busy
// falls while the final group word is still on the outputs.
// The receiver cannot stall; every result must be captured when out_valid is high.
// Synchronous reset (rst_n low) returns the controller to idle and clears out_valid;
// no clearing pass is needed.
module block_cipher_key_expansion_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire bcke_pkg::in_t  in_data,
  output logic                out_valid,
  output bcke_pkg::out_t      out_data
);
  import bcke_pkg::*;

  cmd_t    cmd;
  status_t status;

  bcke_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  bcke_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: hw/rtl/bcke_checker.sv
`default_nettype none
`include "block_cipher_key_expansion_core_macros.svh"
module bcke_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           out_valid,
  input wire bcke_pkg::out_t out_data
);
  import bcke_pkg::*;

  `BCKE_ASSERT_NEXT(a_req_sets_busy, clk, rst_n, start && !busy, busy && !out_valid, "request did not start a burst")
  `BCKE_ASSERT_NEXT(a_whiten_then_group0, clk, rst_n, out_valid && (out_data.word_kind == WORD_WHITEN), out_valid && (out_data.word_kind == WORD_GROUP) && (out_data.group_index == 4'd0), "group 0 must follow the whitening word")
  `BCKE_ASSERT_NOW(a_last_is_group15, clk, rst_n, out_valid && out_data.last_result, (out_data.word_kind == WORD_GROUP) && (out_data.group_index == 4'd15) && !busy, "last result must be group 15 with busy low")
  `BCKE_ASSERT_NEXT(a_group_runs_on, clk, rst_n, out_valid && (out_data.word_kind == WORD_GROUP) && !out_data.last_result, out_valid && (out_data.word_kind == WORD_GROUP) && (out_data.group_index == $past(out_data.group_index) + 4'd1), "subkey groups must run without gaps")

endmodule

bind block_cipher_key_expansion_core bcke_checker u_bcke_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import bcke_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 24;
  localparam int RANDOM_KEYS_PER_PHASE = 40;
  localparam int PHASE_COUNT = 4;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  in_t   in_data = '0;
  logic  busy;
  logic  out_valid;
  out_t  out_data;

  in_t   key_queue[$];
  out_t  schedule_words[$];
  int    sender_idle_pct = 0;
  int    keys_queued = 0;
  int    keys_taken = 0;
  int    words_checked = 0;
  int    errors = 0;
  int    cycles = 0;

  block_cipher_key_expansion_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Expands one master key into the whitening word and the 16 subkey groups.
  function automatic void expand_key(input in_t mkey);
    logic [7:0] mk [16];
    logic [6:0] rc;
    out_t       w;
    int         t, r, n, src;
    for (int b = 0; b < 8; b++) begin
      mk[b]     = mkey.key_low[8*b +: 8];
      mk[b + 8] = mkey.key_high[8*b +: 8];
    end
    w.word_kind   = WORD_WHITEN;
    w.group_index = '0;
    w.key_bytes   = {mk[3], mk[2], mk[1], mk[0], mk[15], mk[14], mk[13], mk[12]};
    w.last_result = 1'b0;
    schedule_words.push_back(w);
    rc = LFSR_SEED;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      w.word_kind   = WORD_GROUP;
      w.group_index = g[3:0];
      w.last_result = (g == GROUP_COUNT - 1);
      for (int j = 0; j < 8; j++) begin
        t = 8 * g + j;
        r = (t >> 4) & 7;
        n = t & 15;
        // The byte offset within each half slips back by one every 16 subkeys.
        if (n < 8) src = (n - r) & 7;
        else src = 8 + ((n - 8 - r) & 7);
        w.key_bytes[8*j +: 8] = mk[src] + {1'b0, rc};
        rc = {rc[3] ^ rc[0], rc[6:1]};
      end
      schedule_words.push_back(w);
    end
  endfunction

  // Mixes fully random halves with halves built from 00, FF and random bytes.
  function automatic logic [63:0] random_key_half();
    logic [63:0] h;
    h = {$urandom, $urandom};
    if ($urandom_range(3, 0) == 0) begin
      for (int b = 0; b < 8; b++) begin
        case ($urandom_range(2, 0))
          0: h[8*b +: 8] = 8'h00;
          1: h[8*b +: 8] = 8'hFF;
          default: ;
        endcase
      end
    end
    return h;
  endfunction

  task automatic queue_key(input logic [63:0] lo, input logic [63:0] hi);
    in_t k;
    k.key_low  = lo;
    k.key_high = hi;
    key_queue.push_back(k);
    keys_queued++;
  endtask

  task automatic report_field(input string name, input int idx,
                              input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: word %0d %s mismatch, expected %h actual %h",
               $time, idx, name, want, got);
      errors++;
    end
  endtask

  // Driver: a request is taken on an edge with start high and busy low.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expand_key(in_data);
        keys_taken++;
      end
      if (!start || !busy) begin
        if (key_queue.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          start   <= 1'b1;
          in_data <= key_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed word must match the oldest pending word.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (schedule_words.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h", $time, out_data);
        errors++;
      end else begin
        want = schedule_words.pop_front();
        report_field("word_kind", words_checked, 64'(want.word_kind),
                     64'(out_data.word_kind));
        report_field("group_index", words_checked, 64'(want.group_index),
                     64'(out_data.group_index));
        report_field("key_bytes", words_checked, want.key_bytes, out_data.key_bytes);
        report_field("last_result", words_checked, 64'(want.last_result),
                     64'(out_data.last_result));
      end
      words_checked++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding",
               cycles, schedule_words.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int phase_idle [PHASE_COUNT];
    phase_idle = '{0, 69, 0, 31};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Extremes, alternating patterns, byte ramps and single set bits.
    queue_key(64'h0, 64'h0);
    queue_key('1, '1);
    queue_key('1, 64'h0);
    queue_key(64'h0, '1);
    queue_key({8{8'hAA}}, {8{8'h55}});
    queue_key({8{8'h55}}, {8{8'hAA}});
    queue_key(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908);
    queue_key(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
    queue_key(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    queue_key(64'hFF00_FF00_FF00_FF00, 64'h00FF_00FF_00FF_00FF);
    queue_key(64'hA6A6_A6A6_A6A6_A6A6, 64'hFFFF_FFFF_0000_0000);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      sender_idle_pct = phase_idle[p];
      for (int i = 0; i < RANDOM_KEYS_PER_PHASE; i++)
        queue_key(random_key_half(), random_key_half());
      // Hold off new keys until the whole phase has drained.
      while (keys_taken != keys_queued || schedule_words.size() != 0)
        @(posedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Expanded %0d master keys (directed extremes plus random) and checked %0d words,",
             keys_taken, words_checked);
    $display("with back-to-back requests and sender gaps of 0, 69 and 31 percent.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
